// ===== rtl/core/mono_page_framebuffer_core_macros.svh =====
// Assertion macros shared by the framebuffer core RTL.
`ifndef MONO_PAGE_FRAMEBUFFER_CORE_MACROS_SVH
`define MONO_PAGE_FRAMEBUFFER_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define MPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MPF_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/mpf_pkg.sv =====
// Shared constants and types of the page framebuffer core.
package mpf_pkg;

    localparam int WIDTH_PIXELS  = 64;
    localparam int HEIGHT_PIXELS = 32;
    localparam int PAGE_COUNT    = (HEIGHT_PIXELS + 7) / 8;
    localparam int STORE_BYTES   = WIDTH_PIXELS * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int WALK_W        = $clog2(WIDTH_PIXELS);

    localparam int IN_W          = 32;
    localparam int OUT_W         = 16;

    localparam int OUT_DEPTH     = 2;
    localparam int PTR_W         = $clog2(OUT_DEPTH);
    localparam int CNT_W         = $clog2(OUT_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_ROP   = 3'd0,
        MODE_COLOR = 3'd1,
        MODE_READ  = 3'd2,
        MODE_FILL  = 3'd3,
        MODE_DUMP  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ROP_COPY = 2'd0,
        ROP_XOR  = 2'd1,
        ROP_CLR  = 2'd2,
        ROP_SET  = 2'd3
    } t_rop;

    typedef struct packed {
        logic       last;
        logic       is_dump;
        logic [7:0] column_byte;
        logic       pixel_white;
    } t_result;

endpackage

// ===== rtl/core/mpf_out_fifo.sv =====
// Two-entry result queue between the store pipeline and the output stream.
module mpf_out_fifo import mpf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_result          i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_result          o_data,
    output logic [CNT_W-1:0] o_count
);

    t_result            r_ent [OUT_DEPTH];
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_ent[r_rp];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        priority if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_data;
        end
    end

`include "mono_page_framebuffer_core_macros.svh"

    `MPF_ASSERT(a_no_overflow, (r_count == CNT_W'(OUT_DEPTH) && !pop) |-> !i_push, "result queue overflow")
    `MPF_ASSERT(a_count_bound, r_count <= CNT_W'(OUT_DEPTH), "result queue count out of range")
    `MPF_ASSERT_NR(a_empty_after_reset, !i_rst_n |=> (r_count == '0), "result queue not empty after reset")

endmodule

// ===== rtl/core/mono_page_framebuffer_core.sv =====
// Top level of the 1bpp page-layout framebuffer core.
// 1bpp framebuffer, page layout (byte = column x page, bit = row & 7), kept in one
// single-port-write, registered-read store of STORE_BYTES bytes. After reset the core
// runs a clearing pass over all STORE_BYTES bytes (256 at 64x32) with o_s_tready low;
// config writes are taken at any time. Per request: a pixel write (raster op or
// color) is a read of the byte then its write-back; a pixel read is registered at the
// store's read port, then pushed into the result queue; a fill rewrites the whole store
// one byte per cycle; a page dump streams WIDTH_PIXELS bytes at one per cycle while
// the sink keeps tready high, tlast on the final byte. Results pass through a two-entry
// queue, so a request can be taken while results wait, as long as the queue has room.
// tuser on the output is 1 for page-dump bytes, 0 for pixel-read results.
module mono_page_framebuffer_core import mpf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // config: raster op
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_data,
    // request stream
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // mode[2:0], col[10:3], row[18:11], value[26:19], page[29:27]
    // result stream
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // pixel_white[0], column_byte[8:1]
    output logic             o_m_tlast,
    output logic             o_m_tuser    // is_dump
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RMW   = 4'b0100,
        S_DUMP  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_rop                r_rop, n_rop;
    t_rop                r_op, n_op;
    logic [ADDR_W-1:0]   r_sweep, n_sweep;
    logic [7:0]          r_fill, n_fill;
    logic [WALK_W-1:0]   r_walk, n_walk;
    logic [ADDR_W-1:0]   r_base, n_base;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [2:0]          r_bit, n_bit;
    logic                r_val, n_val;
    logic                r_rd_pend, n_rd_pend;
    logic                r_pend_dump, n_pend_dump;
    logic                r_pend_last, n_pend_last;
    logic                r_pend_on, n_pend_on;
    logic [2:0]          r_pend_bit, n_pend_bit;

    logic [7:0]          r_mem [STORE_BYTES];
    logic [7:0]          r_rdata;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [7:0]          ram_wdata;

    t_mode               in_mode;
    logic [7:0]          in_col;
    logic [7:0]          in_row;
    logic [7:0]          in_val;
    logic [2:0]          in_page;
    logic                in_on;
    logic [ADDR_W-1:0]   in_addr;
    logic [ADDR_W-1:0]   page_base;

    logic                accept;
    logic                pop;
    logic                space;
    logic [CNT_W:0]      occ_next;
    logic [CNT_W-1:0]    q_count;
    logic                walk_end;
    logic [7:0]          mask;
    logic [7:0]          rmw_byte;
    t_result             push_data;
    t_result             out_data;

    assign in_mode   = t_mode'(i_s_tdata[2:0]);
    assign in_col    = i_s_tdata[10:3];
    assign in_row    = i_s_tdata[18:11];
    assign in_val    = i_s_tdata[26:19];
    assign in_page   = i_s_tdata[29:27];
    assign in_on     = (32'(in_col) < WIDTH_PIXELS) && (32'(in_row) < HEIGHT_PIXELS);
    assign in_addr   = ADDR_W'(32'(in_row[7:3]) * WIDTH_PIXELS + 32'(in_col));
    assign page_base = ADDR_W'(32'(in_page) * WIDTH_PIXELS);

    assign pop      = o_m_tvalid && i_m_tready;
    // queue fill level in the next cycle, before any read issued now lands
    assign occ_next = {1'b0, q_count} + (CNT_W + 1)'(r_rd_pend) - (CNT_W + 1)'(pop);
    assign space    = occ_next < (CNT_W + 1)'(OUT_DEPTH);

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE) && space;
    assign accept      = i_s_tvalid && o_s_tready;
    assign walk_end    = (r_walk == WALK_W'(WIDTH_PIXELS - 1));

    // byte write-back for pixel writes
    assign mask = 8'b1 << r_bit;
    always_comb begin
        unique case (r_op)
            ROP_COPY: rmw_byte = r_val ? (r_rdata | mask) : (r_rdata & ~mask);
            ROP_XOR:  rmw_byte = r_val ? (r_rdata ^ mask) : r_rdata;
            ROP_CLR:  rmw_byte = r_val ? (r_rdata & ~mask) : r_rdata;
            ROP_SET:  rmw_byte = r_val ? (r_rdata | mask) : r_rdata;
            default:  rmw_byte = r_rdata;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_rop       = r_rop;
        n_op        = r_op;
        n_sweep     = r_sweep;
        n_fill      = r_fill;
        n_walk      = r_walk;
        n_base      = r_base;
        n_addr      = r_addr;
        n_bit       = r_bit;
        n_val       = r_val;
        n_rd_pend   = 1'b0;
        n_pend_dump = r_pend_dump;
        n_pend_last = r_pend_last;
        n_pend_on   = r_pend_on;
        n_pend_bit  = r_pend_bit;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = rmw_byte;
        ram_raddr   = in_addr;

        if (i_cfg_valid) begin
            n_rop = t_rop'(i_cfg_data);
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                ram_wdata = r_fill;
                n_sweep   = r_sweep + 1'b1;
                if (r_sweep == ADDR_W'(STORE_BYTES - 1)) begin
                    n_sweep = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (in_mode)
                        MODE_ROP, MODE_COLOR: begin
                            if (in_on) begin
                                n_addr  = in_addr;
                                n_bit   = in_row[2:0];
                                n_val   = in_val[0];
                                n_op    = (in_mode == MODE_COLOR) ? ROP_COPY : r_rop;
                                n_state = S_RMW;
                            end
                        end
                        MODE_READ: begin
                            n_rd_pend   = 1'b1;
                            n_pend_dump = 1'b0;
                            n_pend_last = 1'b1;
                            n_pend_on   = in_on;
                            n_pend_bit  = in_row[2:0];
                        end
                        MODE_FILL: begin
                            n_fill  = in_val;
                            n_sweep = '0;
                            n_state = S_CLEAR;
                        end
                        MODE_DUMP: begin
                            if (32'(in_page) < PAGE_COUNT) begin
                                n_base  = page_base;
                                n_walk  = '0;
                                n_state = S_DUMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RMW: begin
                ram_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_DUMP: begin
                ram_raddr = r_base + ADDR_W'(r_walk);
                if (space) begin
                    n_rd_pend   = 1'b1;
                    n_pend_dump = 1'b1;
                    n_pend_last = walk_end;
                    if (walk_end) begin
                        n_walk  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_walk = r_walk + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_rop     <= ROP_COPY;
            r_sweep   <= '0;
            r_fill    <= '0;
            r_walk    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rop     <= n_rop;
            r_sweep   <= n_sweep;
            r_fill    <= n_fill;
            r_walk    <= n_walk;
            r_rd_pend <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_base      <= n_base;
        r_addr      <= n_addr;
        r_bit       <= n_bit;
        r_val       <= n_val;
        r_pend_dump <= n_pend_dump;
        r_pend_last <= n_pend_last;
        r_pend_on   <= n_pend_on;
        r_pend_bit  <= n_pend_bit;
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_mem[ram_waddr] <= ram_wdata;
        end
        r_rdata <= r_mem[ram_raddr];
    end

    always_comb begin
        if (r_pend_dump) begin
            push_data.pixel_white = 1'b0;
            push_data.column_byte = r_rdata;
            push_data.is_dump     = 1'b1;
            push_data.last        = r_pend_last;
        end else begin
            push_data.pixel_white = r_pend_on ? r_rdata[r_pend_bit] : 1'b1;
            push_data.column_byte = 8'h00;
            push_data.is_dump     = 1'b0;
            push_data.last        = 1'b1;
        end
    end

    mpf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_rd_pend),
        .i_data  (push_data),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (out_data),
        .o_count (q_count)
    );

    assign o_m_tdata = {(OUT_W - 9)'(0), out_data.column_byte, out_data.pixel_white};
    assign o_m_tlast = out_data.last;
    assign o_m_tuser = out_data.is_dump;

`include "mono_page_framebuffer_core_macros.svh"

    `MPF_ASSERT(a_no_accept_in_sweep, (r_state == S_CLEAR) |-> !o_s_tready, "request taken during store sweep")
    `MPF_ASSERT(a_rmw_after_accept, (r_state == S_RMW) |-> $past(accept), "write-back without a request")
    `MPF_ASSERT(a_dump_ends_idle, (r_state == S_DUMP && space && walk_end) |=> (r_state == S_IDLE), "page dump did not finish")

endmodule

// ===== bench/mpf_checker.sv =====
// Scoreboard for the page framebuffer core: shadow frame store, readback prediction, compare.
`timescale 1ns / 1ps

module mpf_checker import mpf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [1:0]       i_cfg_data,
    input  logic             i_req_valid,
    input  logic             i_req_ready,
    input  logic [IN_W-1:0]  i_req_data,
    input  logic             i_res_valid,
    input  logic             i_res_ready,
    input  logic [OUT_W-1:0] i_res_data,
    input  logic             i_res_last,
    input  logic             i_res_user,
    output int               o_fail_count,
    output int               o_pending
);

    logic [7:0] frame_bytes [STORE_BYTES];
    t_rop       raster_op;
    t_result    readback_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        raster_op    = ROP_COPY;
    end

    task automatic report_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
        o_fail_count++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    endtask

    task automatic check_readback();
        t_result want;
        if (readback_q.size() == 0) begin
            o_fail_count++;
            $display("%0t: result with nothing pending, expected none actual tdata=%h tlast=%b tuser=%b",
                     $time, i_res_data, i_res_last, i_res_user);
            return;
        end
        want = readback_q.pop_front();
        if (i_res_data[0] !== want.pixel_white)
            report_field("pixel_white", want.pixel_white, i_res_data[0]);
        if (i_res_data[8:1] !== want.column_byte)
            report_field("column_byte", want.column_byte, i_res_data[8:1]);
        if (i_res_user !== want.is_dump)
            report_field("is_dump", want.is_dump, i_res_user);
        if (i_res_last !== want.last)
            report_field("last", want.last, i_res_last);
    endtask

    task automatic run_frame_op(input logic [IN_W-1:0] word);
        logic [2:0] mode;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] value;
        logic [2:0] page;
        logic [7:0] mask;
        logic [7:0] cur;
        logic       on_screen;
        logic       bit_set;
        int         idx;
        int         base;
        t_result    res;
        mode      = word[2:0];
        col       = word[10:3];
        row       = word[18:11];
        value     = word[26:19];
        page      = word[29:27];
        mask      = 8'd1 << row[2:0];
        bit_set   = value[0];
        on_screen = (int'(col) < WIDTH_PIXELS) && (int'(row) < HEIGHT_PIXELS);
        idx       = int'(row >> 3) * WIDTH_PIXELS + int'(col);
        case (mode)
            MODE_ROP: begin
                if (on_screen) begin
                    cur = frame_bytes[idx];
                    case (raster_op)
                        ROP_COPY: cur = bit_set ? (cur | mask) : (cur & ~mask);
                        ROP_XOR:  if (bit_set) cur = cur ^ mask;
                        ROP_CLR:  if (bit_set) cur = cur & ~mask;
                        default:  if (bit_set) cur = cur | mask;
                    endcase
                    frame_bytes[idx] = cur;
                end
            end
            MODE_COLOR: begin
                if (on_screen)
                    frame_bytes[idx] = bit_set ? (frame_bytes[idx] | mask)
                                               : (frame_bytes[idx] & ~mask);
            end
            MODE_READ: begin
                res             = '0;
                res.last        = 1'b1;
                // off-screen reads come back white
                res.pixel_white = on_screen ? ((frame_bytes[idx] & mask) != 0) : 1'b1;
                readback_q.push_back(res);
            end
            MODE_FILL: begin
                foreach (frame_bytes[i]) frame_bytes[i] = value;
            end
            MODE_DUMP: begin
                if (int'(page) * 8 < HEIGHT_PIXELS) begin
                    base = int'(page) * WIDTH_PIXELS;
                    for (int k = 0; k < WIDTH_PIXELS; k++) begin
                        res             = '0;
                        res.is_dump     = 1'b1;
                        res.column_byte = frame_bytes[base + k];
                        res.last        = (k == WIDTH_PIXELS - 1);
                        readback_q.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (frame_bytes[i]) frame_bytes[i] = 8'd0;
            raster_op = ROP_COPY;
            readback_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) check_readback();
            // a request taken on the same edge as a config write sees the old raster op
            if (i_req_valid && i_req_ready) run_frame_op(i_req_data);
            if (i_cfg_valid && i_cfg_ready) raster_op = t_rop'(i_cfg_data);
        end
        o_pending = readback_q.size();
    end

endmodule

// ===== bench/tb_mono_page_framebuffer_core.sv =====
// Testbench top for the page framebuffer core: clock, reset, request and sink stimulus, verdict.
`timescale 1ns / 1ps

module tb_mono_page_framebuffer_core;
    import mpf_pkg::*;

    localparam int SETTLE_CYCLES  = STORE_BYTES + 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 40;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_data  = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    logic             m_tuser;
    logic             calm      = 1'b0;
    int               sink_stall = 0;
    int               fail_count;
    int               pending;

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    mono_page_framebuffer_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .o_m_tuser   (m_tuser)
    );

    mpf_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_req_valid  (s_tvalid),
        .i_req_ready  (s_tready),
        .i_req_data   (s_tdata),
        .i_res_valid  (m_tvalid),
        .i_res_ready  (m_tready),
        .i_res_data   (m_tdata),
        .i_res_last   (m_tlast),
        .i_res_user   (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // sink back-pressure: random stall bursts, none once calm
    always @(negedge clk) begin
        if (calm) begin
            m_tready = 1'b1;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_tready = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            sink_stall = $urandom_range(0, 4);
            m_tready   = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    task automatic send_request(input logic [2:0] mode, input logic [7:0] col,
                                input logic [7:0] row, input logic [7:0] value,
                                input logic [2:0] page);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tdata  = {2'b00, page, value, row, col, mode};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // block must be idle: all readbacks in, and any fill walk finished
    task automatic drain_frame();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_raster_op(input t_rop op);
        drain_frame();
        cfg_data  = op;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_request();
        int         pick;
        logic [2:0] mode;
        logic [7:0] col;
        logic [7:0] row;
        pick = $urandom_range(0, 99);
        if (pick < 30)      mode = MODE_ROP;
        else if (pick < 55) mode = MODE_COLOR;
        else if (pick < 85) mode = MODE_READ;
        else if (pick < 93) mode = MODE_DUMP;
        else if (pick < 96) mode = MODE_FILL;
        else                mode = 3'($urandom_range(5, 7));
        // mostly on screen, now and then the full field range
        col = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, WIDTH_PIXELS - 1));
        row = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, HEIGHT_PIXELS - 1));
        send_request(mode, col, row, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
    endtask

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("mono_page_framebuffer_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        t_rop phase_op [PHASES];
        phase_op[0] = ROP_XOR;
        phase_op[1] = ROP_CLR;
        phase_op[2] = ROP_SET;
        phase_op[3] = ROP_COPY;
        phase_op[4] = t_rop'($urandom_range(0, 3));
        phase_op[5] = t_rop'($urandom_range(0, 3));

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed: raster op still at its reset value (copy)
        send_request(MODE_READ,  8'd0,   8'd0,   8'h00, 3'd0);
        send_request(MODE_ROP,   8'd0,   8'd0,   8'hFF, 3'd0);
        send_request(MODE_READ,  8'd0,   8'd0,   8'h00, 3'd0);
        send_request(MODE_COLOR, 8'd63,  8'd31,  8'h01, 3'd0);
        send_request(MODE_READ,  8'd63,  8'd31,  8'h00, 3'd0);
        // off-screen writes are dropped, off-screen reads are white
        send_request(MODE_ROP,   8'd64,  8'd0,   8'h01, 3'd0);
        send_request(MODE_COLOR, 8'd0,   8'd32,  8'h01, 3'd0);
        send_request(MODE_COLOR, 8'd255, 8'd255, 8'h01, 3'd7);
        send_request(MODE_READ,  8'd64,  8'd0,   8'h00, 3'd0);
        send_request(MODE_READ,  8'd0,   8'd32,  8'h00, 3'd0);
        send_request(MODE_READ,  8'd255, 8'd255, 8'hFF, 3'd7);
        // copy touches one bit only; upper value bits are don't-care
        send_request(MODE_COLOR, 8'd1,   8'd9,   8'h01, 3'd0);
        send_request(MODE_ROP,   8'd1,   8'd10,  8'h03, 3'd0);
        send_request(MODE_ROP,   8'd1,   8'd9,   8'hFE, 3'd0);
        send_request(MODE_READ,  8'd1,   8'd10,  8'h00, 3'd0);
        send_request(MODE_READ,  8'd1,   8'd9,   8'h00, 3'd0);
        // dumps, including pages past the bottom edge
        send_request(MODE_DUMP,  8'd0,   8'd0,   8'h00, 3'd0);
        send_request(MODE_DUMP,  8'd0,   8'd0,   8'h00, 3'd3);
        send_request(MODE_DUMP,  8'd0,   8'd0,   8'h00, 3'd4);
        send_request(MODE_DUMP,  8'd0,   8'd0,   8'h00, 3'd7);
        send_request(MODE_FILL,  8'd0,   8'd0,   8'hA5, 3'd0);
        send_request(MODE_READ,  8'd0,   8'd0,   8'h00, 3'd0);
        send_request(MODE_READ,  8'd0,   8'd1,   8'h00, 3'd0);
        send_request(MODE_DUMP,  8'd0,   8'd0,   8'h00, 3'd2);
        // unused mode codes
        send_request(3'd5, 8'd3,  8'd3,  8'hFF, 3'd1);
        send_request(3'd6, 8'd7,  8'd7,  8'h01, 3'd2);
        send_request(3'd7, 8'd12, 8'd20, 8'h55, 3'd0);

        for (int p = 0; p < PHASES; p++) begin
            write_raster_op(phase_op[p]);
            if (p == PHASES - 1) calm = 1'b1;
            repeat (PHASE_ITEMS) random_request();
        end

        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("mono_page_framebuffer_core regression: pass");
        else
            $display("mono_page_framebuffer_core regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mpf_pkg.sv
rtl/core/mpf_out_fifo.sv
rtl/core/mono_page_framebuffer_core.sv
bench/mpf_checker.sv
bench/tb_mono_page_framebuffer_core.sv
